### sv/tcfe_pkg.sv
// shared types and codes for the tile cache with farthest-tile eviction
`timescale 1ns / 1ps

package tcfe_pkg;

    localparam int COORD_W  = 8;
    localparam int TAG_W    = 6;
    localparam int SLOT_O_W = 4;
    localparam int DIFF_W   = 10;
    localparam int DIST_W   = 9;

    typedef enum logic [1:0] {
        CMD_REQUEST = 2'd0,
        CMD_EXIST   = 2'd1,
        CMD_CENTRE  = 2'd2,
        CMD_NONE    = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        STAT_DONE     = 3'd0,
        STAT_HIT      = 3'd1,
        STAT_FILLED   = 3'd2,
        STAT_REPLACED = 3'd3,
        STAT_ABSENT   = 3'd4,
        STAT_FAILED   = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROW,
        ST_SCAN,
        ST_DECIDE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic clear;
        logic step;
    } scan_ctl_t;

endpackage

### sv/tcfe_tag_ram.sv
// tag memory of the cache slots, one write and one registered read port
`timescale 1ns / 1ps

module tcfe_tag_ram #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4,
    parameter int DATA_W = 12
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### sv/tcfe_exist_map.sv
// tile existence bitmap, one row per map column, rows cleared by per-row valid bits
`timescale 1ns / 1ps

module tcfe_exist_map #(
    parameter int ROWS  = 64,
    parameter int ROW_W = 64
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     rd_en,
    input  logic [$clog2(ROWS)-1:0]  rd_row,
    output logic [ROW_W-1:0]         rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(ROWS)-1:0]  wr_row,
    input  logic [ROW_W-1:0]         wr_data
);

    logic [ROW_W-1:0] mem [ROWS];
    logic [ROWS-1:0]  row_vld_reg;
    logic [ROW_W-1:0] rd_data_reg;
    logic             rd_vld_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_row] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_row];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_vld_reg <= '0;
            rd_vld_reg  <= 1'b0;
        end else begin
            if (wr_en) begin
                row_vld_reg[wr_row] <= 1'b1;
            end
            if (rd_en) begin
                rd_vld_reg <= row_vld_reg[rd_row];
            end
        end
    end

    // a row never written reads as all zero
    assign rd_data = rd_vld_reg ? rd_data_reg : '0;

endmodule

### sv/tcfe_scan.sv
// slot scan unit: hit match, first free slot and farthest victim, one slot per cycle
`timescale 1ns / 1ps

module tcfe_scan
    import tcfe_pkg::*;
#(
    parameter int SLOT_W = 4
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  scan_ctl_t                  ctl,
    input  logic [SLOT_W-1:0]          idx,
    input  logic                       slot_vld,
    input  logic [TAG_W-1:0]           tag_x,
    input  logic [TAG_W-1:0]           tag_z,
    input  logic [TAG_W-1:0]           req_x,
    input  logic [TAG_W-1:0]           req_z,
    input  logic signed [COORD_W-1:0]  centre_x,
    input  logic signed [COORD_W-1:0]  centre_z,
    output logic                       hit_found,
    output logic [SLOT_W-1:0]          hit_idx,
    output logic                       free_found,
    output logic [SLOT_W-1:0]          free_idx,
    output logic [SLOT_W-1:0]          vict_idx,
    output logic [TAG_W-1:0]           vict_x,
    output logic [TAG_W-1:0]           vict_z
);

    logic                     hit_found_reg;
    logic [SLOT_W-1:0]        hit_idx_reg;
    logic                     free_found_reg;
    logic [SLOT_W-1:0]        free_idx_reg;
    logic [SLOT_W-1:0]        vict_idx_reg;
    logic [TAG_W-1:0]         vict_x_reg;
    logic [TAG_W-1:0]         vict_z_reg;
    logic [DIST_W-1:0]        best_reg;

    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dz;
    logic [DIFF_W-1:0]        ax;
    logic [DIFF_W-1:0]        az;
    logic [DIST_W-1:0]        dist_val;
    logic                     tag_match;

    // manhattan distance from the centre tile
    always_comb begin
        dx = $signed({{(DIFF_W-TAG_W){1'b0}}, tag_x}) - DIFF_W'(centre_x);
        dz = $signed({{(DIFF_W-TAG_W){1'b0}}, tag_z}) - DIFF_W'(centre_z);
        ax = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
        az = dz[DIFF_W-1] ? DIFF_W'(-dz) : DIFF_W'(dz);
        dist_val = DIST_W'(ax[COORD_W-1:0]) + DIST_W'(az[COORD_W-1:0]);
        tag_match = (tag_x == req_x) && (tag_z == req_z);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || ctl.clear) begin
            hit_found_reg  <= 1'b0;
            hit_idx_reg    <= '0;
            free_found_reg <= 1'b0;
            free_idx_reg   <= '0;
            vict_idx_reg   <= '0;
            vict_x_reg     <= '0;
            vict_z_reg     <= '0;
            best_reg       <= '0;
        end else if (ctl.step) begin
            if (slot_vld && !hit_found_reg && tag_match) begin
                hit_found_reg <= 1'b1;
                hit_idx_reg   <= idx;
            end
            if (!slot_vld && !free_found_reg) begin
                free_found_reg <= 1'b1;
                free_idx_reg   <= idx;
            end
            // slot 0 is the victim unless a strictly farther one shows up
            if (idx == '0) begin
                vict_idx_reg <= idx;
                vict_x_reg   <= tag_x;
                vict_z_reg   <= tag_z;
                best_reg     <= slot_vld ? dist_val : '0;
            end else if (slot_vld && (dist_val > best_reg)) begin
                vict_idx_reg <= idx;
                vict_x_reg   <= tag_x;
                vict_z_reg   <= tag_z;
                best_reg     <= dist_val;
            end
        end
    end

    assign hit_found  = hit_found_reg;
    assign hit_idx    = hit_idx_reg;
    assign free_found = free_found_reg;
    assign free_idx   = free_idx_reg;
    assign vict_idx   = vict_idx_reg;
    assign vict_x     = vict_x_reg;
    assign vict_z     = vict_z_reg;

endmodule

### sv/tile_cache_farthest_eviction.sv
// top level of the tile cache with farthest-tile eviction
`timescale 1ns / 1ps

// Fully associative cache of CACHE_SLOTS tile slots plus a MAP_TILES x MAP_TILES
// existence bitmap. One transaction is handled at a time; s_ready is high only
// while the block is idle. A tile request that reaches the cache scans one slot
// per cycle through the scan unit, passing from the row read through the scan
// and the decide step to the finish step. A request for an in-map tile that is
// not in the bitmap, or an in-map existence write, goes from the row read
// straight to the finish step; an off-map request or write, set centre and the
// unused command go to the finish step directly. s_ready returns in the cycle
// the result is presented; while the previous result still waits, the finish
// step stalls until it is taken. The result sits in an output register, so the
// next transaction is taken while it waits. The bitmap needs no clearing pass
// after reset.

module tile_cache_farthest_eviction
    import tcfe_pkg::*;
#(
    parameter int CACHE_SLOTS = 16,
    parameter int MAP_TILES   = 64
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [1:0]                s_command,
    input  logic signed [COORD_W-1:0] s_tile_x,
    input  logic signed [COORD_W-1:0] s_tile_z,
    input  logic                      s_exists_bit,
    input  logic                      s_load_ok,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [2:0]                m_status,
    output logic [SLOT_O_W-1:0]       m_slot,
    output logic                      m_evicted,
    output logic [TAG_W-1:0]          m_evicted_x,
    output logic [TAG_W-1:0]          m_evicted_z
);

    localparam int SLOT_W = (CACHE_SLOTS > 1) ? $clog2(CACHE_SLOTS) : 1;
    localparam int CNT_W  = $clog2(CACHE_SLOTS + 1);
    localparam int MAP_W  = $clog2(MAP_TILES);
    localparam logic [CNT_W-1:0]   SLOT_CNT = CNT_W'(CACHE_SLOTS);
    localparam logic [COORD_W-1:0] MAP_LIM  = COORD_W'(MAP_TILES);

    state_t                     state_reg, state_next;
    cmd_t                       cmd_reg, cmd_next;
    logic signed [COORD_W-1:0]  x_reg, x_next;
    logic signed [COORD_W-1:0]  z_reg, z_next;
    logic                       ebit_reg, ebit_next;
    logic                       ok_reg, ok_next;
    logic signed [COORD_W-1:0]  centre_x_reg, centre_x_next;
    logic signed [COORD_W-1:0]  centre_z_reg, centre_z_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic                       proc_vld_reg, proc_vld_next;
    logic [SLOT_W-1:0]          proc_idx_reg, proc_idx_next;
    logic [CACHE_SLOTS-1:0]     slot_vld_reg, slot_vld_next;
    status_t                    res_status_reg, res_status_next;
    logic [SLOT_O_W-1:0]        res_slot_reg, res_slot_next;
    logic                       res_ev_reg, res_ev_next;
    logic [TAG_W-1:0]           res_evx_reg, res_evx_next;
    logic [TAG_W-1:0]           res_evz_reg, res_evz_next;
    logic                       m_valid_reg, m_valid_next;
    status_t                    m_status_reg, m_status_next;
    logic [SLOT_O_W-1:0]        m_slot_reg, m_slot_next;
    logic                       m_ev_reg, m_ev_next;
    logic [TAG_W-1:0]           m_evx_reg, m_evx_next;
    logic [TAG_W-1:0]           m_evz_reg, m_evz_next;

    logic                       accept;
    logic                       s_in_map;
    logic                       out_free;
    logic                       row_bit;

    logic                       map_rd_en;
    logic [MAP_W-1:0]           map_rd_row;
    logic [MAP_TILES-1:0]       map_rd_data;
    logic                       map_wr_en;
    logic [MAP_TILES-1:0]       map_wr_data;

    logic                       tag_wr_en;
    logic [SLOT_W-1:0]          tag_wr_addr;
    logic                       tag_rd_en;
    logic [2*TAG_W-1:0]         tag_rd_data;

    scan_ctl_t                  scan_ctl;
    logic                       hit_found;
    logic [SLOT_W-1:0]          hit_idx;
    logic                       free_found;
    logic [SLOT_W-1:0]          free_idx;
    logic [SLOT_W-1:0]          vict_idx;
    logic [TAG_W-1:0]           vict_x;
    logic [TAG_W-1:0]           vict_z;
    logic [SLOT_W-1:0]          target;
    logic [SLOT_W+SLOT_O_W-1:0] target_wide;
    logic [SLOT_W+SLOT_O_W-1:0] hit_wide;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign s_in_map = !s_tile_x[COORD_W-1] && ($unsigned(s_tile_x) < MAP_LIM) &&
                      !s_tile_z[COORD_W-1] && ($unsigned(s_tile_z) < MAP_LIM);
    assign row_bit  = map_rd_data[z_reg[MAP_W-1:0]];

    assign target      = free_found ? free_idx : vict_idx;
    assign target_wide = {{SLOT_O_W{1'b0}}, target};
    assign hit_wide    = {{SLOT_O_W{1'b0}}, hit_idx};

    tcfe_exist_map #(
        .ROWS  (MAP_TILES),
        .ROW_W (MAP_TILES)
    ) u_exist_map (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (map_rd_en),
        .rd_row  (map_rd_row),
        .rd_data (map_rd_data),
        .wr_en   (map_wr_en),
        .wr_row  (x_reg[MAP_W-1:0]),
        .wr_data (map_wr_data)
    );

    tcfe_tag_ram #(
        .DEPTH  (CACHE_SLOTS),
        .ADDR_W (SLOT_W),
        .DATA_W (2 * TAG_W)
    ) u_tag_ram (
        .aclk    (aclk),
        .wr_en   (tag_wr_en),
        .wr_addr (tag_wr_addr),
        .wr_data ({x_reg[TAG_W-1:0], z_reg[TAG_W-1:0]}),
        .rd_en   (tag_rd_en),
        .rd_addr (cnt_reg[SLOT_W-1:0]),
        .rd_data (tag_rd_data)
    );

    tcfe_scan #(
        .SLOT_W (SLOT_W)
    ) u_scan (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (scan_ctl),
        .idx        (proc_idx_reg),
        .slot_vld   (slot_vld_reg[proc_idx_reg]),
        .tag_x      (tag_rd_data[2*TAG_W-1:TAG_W]),
        .tag_z      (tag_rd_data[TAG_W-1:0]),
        .req_x      (x_reg[TAG_W-1:0]),
        .req_z      (z_reg[TAG_W-1:0]),
        .centre_x   (centre_x_reg),
        .centre_z   (centre_z_reg),
        .hit_found  (hit_found),
        .hit_idx    (hit_idx),
        .free_found (free_found),
        .free_idx   (free_idx),
        .vict_idx   (vict_idx),
        .vict_x     (vict_x),
        .vict_z     (vict_z)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    case (s_command)
                        CMD_REQUEST, CMD_EXIST: state_next = s_in_map ? ST_ROW : ST_FINISH;
                        default:                state_next = ST_FINISH;
                    endcase
                end
            end
            ST_ROW: begin
                if (cmd_reg == CMD_REQUEST && row_bit) begin
                    state_next = ST_SCAN;
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_SCAN: begin
                if (cnt_reg == SLOT_CNT) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: state_next = ST_FINISH;
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        cmd_next        = cmd_reg;
        x_next          = x_reg;
        z_next          = z_reg;
        ebit_next       = ebit_reg;
        ok_next         = ok_reg;
        centre_x_next   = centre_x_reg;
        centre_z_next   = centre_z_reg;
        cnt_next        = cnt_reg;
        proc_vld_next   = 1'b0;
        proc_idx_next   = proc_idx_reg;
        slot_vld_next   = slot_vld_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_ev_next     = res_ev_reg;
        res_evx_next    = res_evx_reg;
        res_evz_next    = res_evz_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_status_next   = m_status_reg;
        m_slot_next     = m_slot_reg;
        m_ev_next       = m_ev_reg;
        m_evx_next      = m_evx_reg;
        m_evz_next      = m_evz_reg;
        map_rd_en       = 1'b0;
        map_rd_row      = s_tile_x[MAP_W-1:0];
        map_wr_en       = 1'b0;
        map_wr_data     = map_rd_data;
        tag_wr_en       = 1'b0;
        tag_wr_addr     = target;
        tag_rd_en       = 1'b0;
        scan_ctl        = '{clear: 1'b0, step: proc_vld_reg};

        map_wr_data[z_reg[MAP_W-1:0]] = ebit_reg;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd_next        = cmd_t'(s_command);
                    x_next          = s_tile_x;
                    z_next          = s_tile_z;
                    ebit_next       = s_exists_bit;
                    ok_next         = s_load_ok;
                    map_rd_en       = 1'b1;
                    res_status_next = (s_command == CMD_REQUEST) ? STAT_ABSENT : STAT_DONE;
                    res_slot_next   = '0;
                    res_ev_next     = 1'b0;
                    res_evx_next    = '0;
                    res_evz_next    = '0;
                    if (s_command == CMD_CENTRE) begin
                        centre_x_next = s_tile_x;
                        centre_z_next = s_tile_z;
                    end
                end
            end
            ST_ROW: begin
                if (cmd_reg == CMD_EXIST) begin
                    map_wr_en = 1'b1;
                end
                scan_ctl.clear = 1'b1;
                cnt_next       = '0;
            end
            ST_SCAN: begin
                if (cnt_reg != SLOT_CNT) begin
                    tag_rd_en     = 1'b1;
                    proc_vld_next = 1'b1;
                    proc_idx_next = cnt_reg[SLOT_W-1:0];
                    cnt_next      = cnt_reg + 1'b1;
                end
            end
            ST_DECIDE: begin
                if (hit_found) begin
                    res_status_next = STAT_HIT;
                    res_slot_next   = hit_wide[SLOT_O_W-1:0];
                end else begin
                    res_ev_next  = !free_found;
                    res_evx_next = free_found ? '0 : vict_x;
                    res_evz_next = free_found ? '0 : vict_z;
                    if (ok_reg) begin
                        tag_wr_en             = 1'b1;
                        slot_vld_next[target] = 1'b1;
                        res_status_next       = free_found ? STAT_FILLED : STAT_REPLACED;
                        res_slot_next         = target_wide[SLOT_O_W-1:0];
                    end else begin
                        slot_vld_next[target] = 1'b0;
                        res_status_next       = STAT_FAILED;
                        res_slot_next         = '0;
                    end
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_slot_next   = res_slot_reg;
                    m_ev_next     = res_ev_reg;
                    m_evx_next    = res_evx_reg;
                    m_evz_next    = res_evz_reg;
                end
            end
            default: begin
                cnt_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            centre_x_reg <= '1;
            centre_z_reg <= '1;
            cnt_reg      <= '0;
            proc_vld_reg <= 1'b0;
            slot_vld_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            centre_x_reg <= centre_x_next;
            centre_z_reg <= centre_z_next;
            cnt_reg      <= cnt_next;
            proc_vld_reg <= proc_vld_next;
            slot_vld_reg <= slot_vld_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg        <= cmd_next;
        x_reg          <= x_next;
        z_reg          <= z_next;
        ebit_reg       <= ebit_next;
        ok_reg         <= ok_next;
        proc_idx_reg   <= proc_idx_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        res_ev_reg     <= res_ev_next;
        res_evx_reg    <= res_evx_next;
        res_evz_reg    <= res_evz_next;
        m_status_reg   <= m_status_next;
        m_slot_reg     <= m_slot_next;
        m_ev_reg       <= m_ev_next;
        m_evx_reg      <= m_evx_next;
        m_evz_reg      <= m_evz_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_status    = m_status_reg;
    assign m_slot      = m_slot_reg;
    assign m_evicted   = m_ev_reg;
    assign m_evicted_x = m_evx_reg;
    assign m_evicted_z = m_evz_reg;

endmodule
